### design/srq_pkg.sv
// srq_pkg: shared types and codes for the searchable ring queue
// holds the entry record, the per-cell control group and the operation and error codes
// no dependencies
`default_nettype none

package srq_pkg;

  localparam int unsigned LINE_W = 58;
  localparam int unsigned FULL_W = 64;
  localparam int unsigned TAG_W  = 16;

  // operation kinds
  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_EMPTY     = 2'd2;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] line_address;
    logic [FULL_W-1:0] full_address;
    logic [TAG_W-1:0]  payload_tag;
  } srq_entry_t;

  typedef struct packed {
    logic write;     // load the new entry from the request
    logic compact;   // take the neighbor's entry if inside the shift window
    logic snapshot;  // capture the compare result
  } srq_cell_ctrl_t;

endpackage

`default_nettype wire

### design/srq_cell.sv
// srq_cell: one ring slot of the searchable ring queue
// holds one entry, compares it against the request key and takes its successor's entry
// depends on srq_pkg
`default_nettype none

module srq_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SLOT  = 0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire srq_pkg::srq_cell_ctrl_t  ctrl_i,
  input  wire [$clog2(DEPTH)-1:0]       head_i,
  input  wire [$clog2(DEPTH+1)-1:0]     count_i,
  input  wire [$clog2(DEPTH)-1:0]       scan_off_i,
  input  wire                           full_mode_i,
  input  wire [srq_pkg::LINE_W-1:0]     key_line_i,
  input  wire [srq_pkg::FULL_W-1:0]     key_full_i,
  input  wire srq_pkg::srq_entry_t      wr_entry_i,
  input  wire srq_pkg::srq_entry_t      next_entry_i,
  output srq_pkg::srq_entry_t           entry_o,
  output logic                          match_o
);
  import srq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  srq_entry_t    entry_q;
  logic          match_q;
  logic [IW:0]   diff;
  logic [IW:0]   off_w;
  logic [CW-1:0] off;
  logic          held;
  logic          in_window;
  logic          key_eq;

  // distance of this slot from the head, in ring order
  always_comb begin
    diff      = (IW+1)'(SLOT) - {1'b0, head_i};
    off_w     = diff[IW] ? diff + (IW+1)'(DEPTH) : diff;
    off       = CW'(off_w[IW-1:0]);
    held      = off < count_i;
    in_window = (off >= CW'(scan_off_i)) && ((off + CW'(1)) < count_i);
    key_eq    = full_mode_i ? (entry_q.full_address == key_full_i)
                            : (entry_q.line_address == key_line_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      entry_q <= wr_entry_i;
    end else if (ctrl_i.compact && in_window) begin
      entry_q <= next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.snapshot) begin
      match_q <= held && key_eq;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

### design/searchable_ring_queue_unit.sv
// searchable_ring_queue_unit: circular request queue with associative search
// add, remove, and search or delete on an empty queue finish at accept; other searches and
// deletes scan: every cell compares at accept, then a scan walks the captured match bits
// from the head, one slot a cycle, until the oldest hit or the last entry
// busy refuses new commands during a scan; the receiver cannot stall
// reset clears pointers, count, mode and control; entry storage stays undefined
`default_nettype none

module searchable_ring_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // command channel
  input  wire                           start,
  output logic                          busy,
  input  wire [1:0]                     kind_i,
  input  wire [srq_pkg::LINE_W-1:0]     line_address_i,
  input  wire [srq_pkg::FULL_W-1:0]     full_address_i,
  input  wire [srq_pkg::TAG_W-1:0]      payload_tag_i,
  // match-mode register
  input  wire                           cfg_we_i,
  input  wire                           cfg_wdata_i,
  // result beat
  output logic                          done_o,
  output logic                          hit_o,
  output logic [3:0]                    slot_index_o,
  output logic [1:0]                    error_code_o,
  output logic [4:0]                    count_after_o,
  output logic [srq_pkg::LINE_W-1:0]    out_line_address_o,
  output logic [srq_pkg::FULL_W-1:0]    out_full_address_o,
  output logic [srq_pkg::TAG_W-1:0]     out_payload_tag_o
);
  import srq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // step a slot index forward by one around the ring
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    logic [IW:0] s;
    s = {1'b0, v} + (IW+1)'(1);
    wrap_inc = (s == (IW+1)'(QUEUE_DEPTH)) ? '0 : s[IW-1:0];
  endfunction

  // control state
  logic          state_q, state_d;
  logic          op_del_q, op_del_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          mode_q;

  // result beat registers
  logic          done_q, done_d;
  logic          hit_q, hit_d;
  logic [3:0]    slot_q, slot_d;
  logic [1:0]    err_q, err_d;
  logic [4:0]    cnt_q, cnt_d;
  srq_entry_t    out_q, out_d;

  // cell row
  srq_entry_t     cell_entry [QUEUE_DEPTH];
  logic           cell_match [QUEUE_DEPTH];
  srq_cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];
  srq_entry_t     new_entry;

  logic          accept;
  logic          full;
  logic          empty;
  logic          add_go;
  logic          snap_go;
  logic          compact_go;
  logic [IW:0]   scan_sum;
  logic [IW-1:0] scan_slot;
  logic          scan_hit;
  logic          scan_last;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] count_inc;

  assign busy   = (state_q == ST_SCAN);
  assign accept = start && !busy;
  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign count_dec = count_q - CW'(1);
  assign count_inc = count_q + CW'(1);

  assign new_entry = '{line_address: line_address_i,
                       full_address: full_address_i,
                       payload_tag:  payload_tag_i};

  // scan position: head plus offset, wrapped once
  always_comb begin
    scan_sum  = {1'b0, head_q} + {1'b0, k_q};
    scan_slot = (scan_sum >= (IW+1)'(QUEUE_DEPTH)) ?
                IW'(scan_sum - (IW+1)'(QUEUE_DEPTH)) : scan_sum[IW-1:0];
    scan_hit  = cell_match[scan_slot];
    scan_last = ((CW'(k_q) + CW'(1)) == count_q);
  end

  assign add_go     = accept && (kind_i == KIND_ADD) && !full;
  assign snap_go    = accept && ((kind_i == KIND_SEARCH) || (kind_i == KIND_DELETE));
  assign compact_go = (state_q == ST_SCAN) && scan_hit && op_del_q;

  // each cell sits in a fixed ring slot and pulls from its successor on compaction
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % QUEUE_DEPTH;

    assign cell_ctrl[g] = '{write:    add_go && (tail_q == IW'(g)),
                            compact:  compact_go,
                            snapshot: snap_go};

    srq_cell #(
      .DEPTH (QUEUE_DEPTH),
      .SLOT  (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[g]),
      .head_i       (head_q),
      .count_i      (count_q),
      .scan_off_i   (k_q),
      .full_mode_i  (mode_q),
      .key_line_i   (line_address_i),
      .key_full_i   (full_address_i),
      .wr_entry_i   (new_entry),
      .next_entry_i (cell_entry[NXT]),
      .entry_o      (cell_entry[g]),
      .match_o      (cell_match[g])
    );
  end

  // sequencer: add, remove and empty-queue ops finish at accept, search and delete walk the match bits
  always_comb begin
    state_d  = state_q;
    op_del_d = op_del_q;
    k_d      = k_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    done_d   = 1'b0;
    hit_d    = 1'b0;
    slot_d   = '0;
    err_d    = ERR_OK;
    cnt_d    = 5'(count_q);
    out_d    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_ADD: begin
              done_d = 1'b1;
              if (full) begin
                err_d = ERR_FULL;
              end else begin
                slot_d  = 4'(tail_q);
                tail_d  = wrap_inc(tail_q);
                count_d = count_inc;
                cnt_d   = 5'(count_inc);
              end
            end
            KIND_REMOVE: begin
              done_d = 1'b1;
              if (empty) begin
                err_d = ERR_EMPTY;
              end else begin
                out_d   = cell_entry[head_q];
                slot_d  = 4'(head_q);
                head_d  = wrap_inc(head_q);
                count_d = count_dec;
                cnt_d   = 5'(count_dec);
              end
            end
            default: begin
              // search or delete
              if (empty) begin
                done_d = 1'b1;
                err_d  = (kind_i == KIND_DELETE) ? ERR_NOT_FOUND : ERR_OK;
              end else begin
                state_d  = ST_SCAN;
                op_del_d = (kind_i == KIND_DELETE);
                k_d      = '0;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          slot_d  = 4'(scan_slot);
          state_d = ST_IDLE;
          if (op_del_q) begin
            // cells in the window already shift this edge
            tail_d  = (tail_q == '0) ? IW'(QUEUE_DEPTH - 1) : tail_q - IW'(1);
            count_d = count_dec;
            cnt_d   = 5'(count_dec);
          end
        end else if (scan_last) begin
          done_d  = 1'b1;
          err_d   = op_del_q ? ERR_NOT_FOUND : ERR_OK;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_del_q <= 1'b0;
      k_q      <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      mode_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_del_q <= op_del_d;
      k_q      <= k_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // result payload, valid only with the strobe
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    slot_q <= slot_d;
    err_q  <= err_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign done_o             = done_q;
  assign hit_o              = hit_q;
  assign slot_index_o       = slot_q;
  assign error_code_o       = err_q;
  assign count_after_o      = cnt_q;
  assign out_line_address_o = out_q.line_address;
  assign out_full_address_o = out_q.full_address;
  assign out_payload_tag_o  = out_q.payload_tag;

  // occupancy stays within the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // a successful add grows the queue by exactly one
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_go |=> (count_q == $past(count_inc)))
    else $error("add did not bump occupancy");

  // a scan that finds its entry ends with one result beat and returns to idle
  a_scan_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && scan_hit |=> done_q && hit_q && (state_q == ST_IDLE))
    else $error("scan hit did not finish");

  // a full-queue reject reports a full count
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (err_q == ERR_FULL) |-> (cnt_q == 5'(QUEUE_DEPTH)))
    else $error("full error with partial occupancy");

endmodule

`default_nettype wire
